/* hw/rtl/vwp_pkg.sv */
package vwp_pkg;

  // Operation codes of an input item.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam logic [7:0] CFG_VP_X = 8'd0;
  localparam logic [7:0] CFG_VP_Y = 8'd1;
  localparam logic [7:0] CFG_VP_W = 8'd2;
  localparam logic [7:0] CFG_VP_H = 8'd3;

  // One input item as it appears on the push side.
  typedef struct packed {
    logic              op;
    logic [4:0]        coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
  } vwp_in_t;

  // One result item as it appears on the pop side.
  typedef struct packed {
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] win_z;
    logic              valid_proj;
  } vwp_out_t;

  // A classified command handed from the front to the back.
  typedef struct packed {
    logic              is_proj;
    logic [4:0]        index;
    logic signed [31:0] value;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vwp_cmd_t;

  // Viewport settings passed to the back end.
  typedef struct packed {
    logic [15:0] vp_x;
    logic [15:0] vp_y;
    logic [15:0] vp_w;
    logic [15:0] vp_h;
  } vwp_view_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

/* hw/rtl/vwp_ram.sv */
module vwp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/vwp_front.sv */
module vwp_front
  import vwp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  vwp_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output vwp_cmd_t cmd
);

  vwp_cmd_t   slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  vwp_cmd_t   cls;

  // Classify the incoming item into a command.
  always_comb begin
    cls.is_proj = (in_data.op == OP_PROJECT);
    cls.index   = in_data.coef_index;
    cls.value   = in_data.coef_value;
    cls.x       = in_data.obj_x;
    cls.y       = in_data.obj_y;
    cls.z       = in_data.obj_z;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= cls;
    end
  end

endmodule

/* hw/rtl/vwp_back.sv */
module vwp_back
  import vwp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  vwp_cmd_t  cmd,
  input  vwp_view_t view,
  output logic      res_valid,
  input  logic      res_pop,
  output vwp_out_t  res
);

  localparam int DW  = 32 + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ISSUE = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_DIVI  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_NDC   = 4'd5;
  localparam logic [3:0] S_MAPA  = 4'd6;
  localparam logic [3:0] S_MAPB  = 4'd7;
  localparam logic [3:0] S_MAPC  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] CLAMP = 64'sd1 <<< 45;

  logic [3:0]         state;
  logic               phase;
  logic [3:0]         cnt;
  logic [1:0]         k;

  // Multiply-accumulate pipeline.
  logic [31:0]        ram_q;
  logic               v1;
  logic [3:0]         tag1;
  logic               v2;
  logic [3:0]         tag2;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] mac_sum;
  logic signed [31:0] vec [4];
  logic signed [31:0] c4 [4];

  // Divider.
  logic [31:0]        den;
  logic [31:0]        rem;
  logic [DW-1:0]      quo;
  logic [DCW-1:0]     dcnt;
  logic               neg;
  logic [32:0]        rem_s;
  logic               ge;
  logic [31:0]        cnum;
  logic signed [63:0] qx;
  logic signed [63:0] ndc;
  logic signed [63:0] ndc_c;

  // Viewport map.
  logic signed [47:0] a_reg;
  logic [39:0]        plo;
  logic signed [40:0] phi;
  logic [15:0]        size;
  logic [15:0]        org;
  logic signed [63:0] span;
  logic signed [63:0] wpos;

  logic signed [31:0] rx;
  logic signed [31:0] ry;
  logic signed [31:0] rz;
  logic               rv;
  logic               out_free;

  vwp_ram #(.WIDTH(32), .DEPTH(32)) u_coef (
    .clk   (clk),
    .we    (state == S_IDLE && cmd_valid && !cmd.is_proj),
    .waddr (cmd.index),
    .wdata (cmd.value),
    .raddr ({phase, cnt[1:0], cnt[3:2]}),
    .rdata (ram_q)
  );

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign out_free = !res_valid || res_pop;

  // Combinational helpers for accumulate, divide and map.
  always_comb begin
    mac_sum = acc + (prod >>> FRAC_BITS);
    rem_s   = {rem, quo[DW-1]};
    ge      = (rem_s >= {1'b0, den});
    cnum    = c4[k];
    qx      = $signed(64'(quo));
    ndc     = neg ? -qx : qx;
    if (ndc > CLAMP) begin
      ndc_c = CLAMP;
    end else if (ndc < -CLAMP) begin
      ndc_c = -CLAMP;
    end else begin
      ndc_c = ndc;
    end
    size = (k == 2'd0) ? view.vp_w : view.vp_h;
    org  = (k == 2'd0) ? view.vp_x : view.vp_y;
    span = ((64'(phi) <<< 24) + $signed({24'b0, plo})) >>> 1;
    wpos = $signed(64'(org) << FRAC_BITS) + span;
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_ISSUE);
      v2 <= v1;
    end
  end

  // Multiply and accumulate stages.
  always_ff @(posedge clk) begin
    tag1 <= cnt;
    tag2 <= tag1;
    prod <= $signed(ram_q) * vec[tag1[1:0]];
    if (state == S_IDLE) begin
      acc <= 64'sd0;
    end else if (v2) begin
      if (tag2[1:0] == 2'd3) begin
        c4[tag2[3:2]] <= sat32(mac_sum);
        acc           <= 64'sd0;
      end else begin
        acc <= mac_sum;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // A result is loaded when the output is free and cleared when it is transferred.
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.is_proj) begin
            vec[0] <= cmd.x;
            vec[1] <= cmd.y;
            vec[2] <= cmd.z;
            vec[3] <= ONE[31:0];
            phase  <= 1'b0;
            cnt    <= 4'd0;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            if (!phase) begin
              vec   <= c4;
              phase <= 1'b1;
              cnt   <= 4'd0;
              state <= S_ISSUE;
            end else begin
              k     <= 2'd0;
              state <= S_DIVI;
            end
          end
        end
        S_DIVI: begin
          if (c4[3] == 32'sd0) begin
            rx    <= 32'sd0;
            ry    <= 32'sd0;
            rz    <= 32'sd0;
            rv    <= 1'b0;
            state <= S_OUT;
          end else begin
            quo   <= {(cnum[31] ? 32'(-cnum) : cnum), FRAC_BITS'(0)};
            den   <= c4[3][31] ? 32'(-c4[3]) : c4[3];
            rem   <= 32'd0;
            neg   <= cnum[31] ^ c4[3][31];
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? 32'(rem_s - {1'b0, den}) : rem_s[31:0];
          quo  <= {quo[DW-2:0], ge};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(DW - 1)) begin
            state <= S_NDC;
          end
        end
        S_NDC: begin
          if (k == 2'd2) begin
            rz    <= sat32((ONE + ndc) >>> 1);
            rv    <= 1'b1;
            state <= S_OUT;
          end else begin
            a_reg <= 48'(ONE + ndc_c);
            state <= S_MAPA;
          end
        end
        S_MAPA: begin
          plo   <= 40'(a_reg[23:0]) * 40'(size);
          state <= S_MAPB;
        end
        S_MAPB: begin
          phi   <= $signed(a_reg[47:24]) * $signed({1'b0, size});
          state <= S_MAPC;
        end
        S_MAPC: begin
          if (k == 2'd0) begin
            rx <= sat32(wpos);
          end else begin
            ry <= sat32(wpos);
          end
          k     <= k + 2'd1;
          state <= S_DIVI;
        end
        S_OUT: begin
          if (out_free) begin
            res.win_x      <= rx;
            res.win_y      <= ry;
            res.win_z      <= rz;
            res.valid_proj <= rv;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/vertex_window_projection.sv */
// Projects object points to window coordinates with two 4x4 Q16.16 matrices
// (model-view at coefficient indexes 0-15, projection at 16-31, column-major)
// held in a 32-entry coefficient RAM. A coefficient write passes through the
// command queue. A projection streams its two matrix-vector products, 16 RAM
// reads each, through one 32x32 multiplier; each of the three divides by w
// runs a restoring divider that yields one quotient bit per cycle, and the x
// and y viewport maps step through states S_MAPA, S_MAPB and S_MAPC. Write
// all 32 coefficients before the first projection, and write configuration
// only while no item is in flight.
module vertex_window_projection
  import vwp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  vwp_in_t     in_data,
  output logic        empty,
  input  logic        pop,
  output vwp_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  vwp_view_t view;
  logic      cmd_valid;
  logic      cmd_take;
  vwp_cmd_t  cmd;
  logic      res_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  // Viewport registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      view <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VP_X: view.vp_x <= cfg_data;
        CFG_VP_Y: view.vp_y <= cfg_data;
        CFG_VP_W: view.vp_w <= cfg_data;
        CFG_VP_H: view.vp_h <= cfg_data;
        default: ;
      endcase
    end
  end

  vwp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  vwp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .view      (view),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (out_data)
  );

endmodule

/* hw/rtl/vwp_check.sv */
module vwp_check
  import vwp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input vwp_out_t    out_data
);

  // A waiting result holds until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("result changed before transfer");

  // Reset leaves no result and an open input.
  a_reset: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queue not clear after reset");

  // A failed projection reports zero coordinates.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !out_data.valid_proj |->
      out_data.win_x == 32'sd0 && out_data.win_y == 32'sd0 &&
      out_data.win_z == 32'sd0)
    else $error("failed projection with nonzero coordinates");

endmodule

bind vertex_window_projection vwp_check u_check (.*);

/* tb/sv/tb_vertex_window_projection.sv */
`timescale 1ns / 100ps

module tb_vertex_window_projection;
  import vwp_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint NDC_LIMIT = longint'(1) << 45;
  localparam int RANDOM_ITEMS = 1530;
  localparam int PHASES = 5;
  localparam int SETTLE_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam logic [7:0] CFG_UNUSED = 8'd200;

  // Projection predictor with its own copy of the coefficient RAM and viewport.
  class projection_scoreboard;
    logic signed [31:0] coef_mem [32];
    logic [15:0] vp_x, vp_y, vp_w, vp_h;
    vwp_out_t pending_q[$];
    int errors;

    function new();
      foreach (coef_mem[i]) coef_mem[i] = '0;
      vp_x = '0; vp_y = '0; vp_w = '0; vp_h = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] data);
      case (idx)
        CFG_VP_X: vp_x = data;
        CFG_VP_Y: vp_y = data;
        CFG_VP_W: vp_w = data;
        CFG_VP_H: vp_h = data;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // One 4x4 matrix times vector, each product floored back to Q format.
    function void mat_mul(output longint res[4], input int base, input longint v[4]);
      longint acc;
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int c = 0; c < 4; c++) begin
          acc += (longint'(coef_mem[(base + c * 4 + r) & 31]) * v[c]) >>> FRAC;
        end
        res[r] = clamp32(acc);
      end
    endfunction

    function longint to_window(logic [15:0] org, logic [15:0] size, longint ndc);
      longint span;
      if (ndc > NDC_LIMIT) ndc = NDC_LIMIT;
      if (ndc < -NDC_LIMIT) ndc = -NDC_LIMIT;
      span = ((ONE + ndc) * longint'({1'b0, size})) >>> 1;
      return clamp32(longint'({1'b0, org}) * ONE + span);
    endfunction

    // Note an accepted input: writes update the RAM, projections queue a result.
    function void note_input(vwp_in_t it);
      longint obj[4], eye[4], clip[4];
      longint nx, ny, nz;
      vwp_out_t r;
      if (it.op == OP_WRITE) begin
        coef_mem[it.coef_index] = it.coef_value;
        return;
      end
      obj[0] = longint'(it.obj_x);
      obj[1] = longint'(it.obj_y);
      obj[2] = longint'(it.obj_z);
      obj[3] = ONE;
      mat_mul(eye, 0, obj);
      mat_mul(clip, 16, eye);
      r = '0;
      if (clip[3] != 0) begin
        nx = (clip[0] * ONE) / clip[3];
        ny = (clip[1] * ONE) / clip[3];
        nz = (clip[2] * ONE) / clip[3];
        r.win_x = 32'(to_window(vp_x, vp_w, nx));
        r.win_y = 32'(to_window(vp_y, vp_h, ny));
        r.win_z = 32'(clamp32((ONE + nz) >>> 1));
        r.valid_proj = 1'b1;
      end
      pending_q.push_back(r);
    endfunction

    function void check(vwp_out_t got);
      vwp_out_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: win_x %0d", got.win_x);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.win_x !== want.win_x) begin
        $error("win_x: expected %0d, actual %0d", want.win_x, got.win_x);
        errors++;
      end
      if (got.win_y !== want.win_y) begin
        $error("win_y: expected %0d, actual %0d", want.win_y, got.win_y);
        errors++;
      end
      if (got.win_z !== want.win_z) begin
        $error("win_z: expected %0d, actual %0d", want.win_z, got.win_z);
        errors++;
      end
      if (got.valid_proj !== want.valid_proj) begin
        $error("valid_proj: expected %0d, actual %0d", want.valid_proj, got.valid_proj);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  vwp_in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  vwp_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic calm = 1'b0;
  longint cycles = 0;
  projection_scoreboard sb;

  vertex_window_projection DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check each transfer and stall pop at random.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check(out_data);
    pop <= !rst && (calm || $urandom_range(99) >= 20);
  end

  // Push one item, sometimes with a random gap in front of it, and wait for its transfer.
  task automatic send(vwp_in_t it);
    if (!calm && $urandom_range(99) < 20) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_input(it);
  endtask

  task automatic write_coef(int idx, int value);
    vwp_in_t it;
    it = '0;
    it.op = OP_WRITE;
    it.coef_index = idx[4:0];
    it.coef_value = value;
    send(it);
  endtask

  task automatic project(int x, int y, int z);
    vwp_in_t it;
    it = '0;
    it.op = OP_PROJECT;
    it.obj_x = x;
    it.obj_y = y;
    it.obj_z = z;
    send(it);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic set_viewport(logic [15:0] x, logic [15:0] y, logic [15:0] w, logic [15:0] h);
    write_reg(CFG_VP_X, x);
    write_reg(CFG_VP_Y, y);
    write_reg(CFG_VP_W, w);
    write_reg(CFG_VP_H, h);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every expected result has arrived and the block has settled.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly modest Q16.16 values so results land inside the window.
  function automatic int modest_q(int range_bits);
    if ($urandom_range(99) < 8) return int'($urandom());
    return int'($urandom_range(0, 2 ** range_bits)) - (2 ** (range_bits - 1));
  endfunction

  function automatic vwp_in_t random_item();
    vwp_in_t it;
    it.op = ($urandom_range(99) < 35) ? OP_WRITE : OP_PROJECT;
    it.coef_index = 5'($urandom());
    it.coef_value = ($urandom_range(99) < 10) ? 32'sd0 : modest_q(19);
    it.obj_x = modest_q(21);
    it.obj_y = modest_q(21);
    it.obj_z = modest_q(21);
    // Keep the perspective row sane half of the time.
    if (it.op == OP_WRITE && it.coef_index == 5'd31 && $urandom_range(1)) begin
      it.coef_value = 32'(ONE);
    end
    return it;
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_viewport(16'd10, 16'd20, 16'd640, 16'd480);
    write_reg(CFG_UNUSED, 16'hffff);
    cfg_valid <= 1'b0;

    // Identity model-view and projection fill every RAM entry.
    for (int i = 0; i < 32; i++) begin
      write_coef(i, ((i % 16) % 5 == 0) ? int'(ONE) : 0);
    end
    project(0, 0, 0);
    project(int'(ONE), -int'(ONE), int'(ONE) / 2);
    project(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    project(32'sh80000000, 32'sh80000000, 32'sh80000000);
    // Zero clip w.
    write_coef(31, 0);
    project(int'(ONE), int'(ONE), int'(ONE));
    // Perspective: w = -z.
    write_coef(27, -int'(ONE));
    project(int'(ONE), int'(ONE) * 2, -int'(ONE) * 2);
    // Tiny w drives the normalized value far past the window.
    write_coef(27, 0);
    write_coef(31, 1);
    project(int'(ONE) * 100, -int'(ONE) * 100, int'(ONE));
    // Extreme coefficients.
    write_coef(0, 32'sh7fffffff);
    write_coef(5, 32'sh80000000);
    write_coef(31, int'(ONE));
    project(int'(ONE) * 3, int'(ONE) * 3, 0);
    write_coef(0, int'(ONE));
    write_coef(5, int'(ONE));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_viewport(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        1: set_viewport(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: set_viewport(16'd0, 16'd0, 16'hffff, 16'hffff);
        default: set_viewport(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        calm <= (p == 2) && (n >= 50) && (n < 200);
        send(random_item());
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
